>>> rtl/core/ierf_pkg.sv
package ierf_pkg;

  // Default sizes of the event ring and of one read burst.
  localparam int unsigned RING_DEPTH_DEF = 256;
  localparam int unsigned MAX_READ_DEF   = 64;

  // Fixed field widths.
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned XY_W    = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned BTN_W   = 3;

  // Configuration port.
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH_MOUSE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_KEY   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ       = 2'd2;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_GRAB = 1'b0;

  // Event kinds.
  localparam logic KIND_MOUSE = 1'b0;
  localparam logic KIND_KEY   = 1'b1;

  // One queued event, 50 bits.
  typedef struct packed {
    logic signed [XY_W-1:0] y;
    logic signed [XY_W-1:0] x;
    logic                   pressed;
    logic [BYTE_W-1:0]      code;
    logic [BYTE_W-1:0]      flags;
    logic                   kind;
  } ev_t;

  // Controller to datapath.
  typedef struct packed {
    logic push;
    logic load;
    logic step;
    logic emit_empty;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic ring_empty;
    logic last_step;
  } dp_stat_t;

endpackage

>>> rtl/core/ierf_regs.sv
module ierf_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ierf_pkg::APB_AW-1:0] paddr,
  input  logic [ierf_pkg::APB_DW-1:0] pwdata,
  output logic [ierf_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output logic                        grab
);
  import ierf_pkg::*;

  logic grab_r;
  logic grab_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    grab_nxt = grab_r;
    if (wr_en && (paddr[2] == REG_GRAB)) begin
      grab_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grab_r <= 1'b0;
    end else begin
      grab_r <= grab_nxt;
    end
  end

  // Only the low bits of paddr below the word bit are ignored; the second word reads zero.
  assign prdata = (paddr[2] == REG_GRAB) ? {{(APB_DW-1){1'b0}}, grab_r} : '0;
  assign grab   = grab_r;

endmodule

>>> rtl/core/ierf_ctrl.sv
module ierf_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ierf_pkg::CMD_W-1:0] in_cmd,
  input  ierf_pkg::dp_stat_t         stat,
  output ierf_pkg::ctrl_cmd_t        cmd,
  output logic                       busy
);
  import ierf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = start && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((in_cmd == CMD_PUSH_MOUSE) || (in_cmd == CMD_PUSH_KEY)) begin
            cmd.push = 1'b1;
          end else if (in_cmd == CMD_READ) begin
            if (stat.ring_empty) begin
              cmd.emit_empty = 1'b1;
            end else begin
              cmd.load  = 1'b1;
              state_nxt = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        cmd.step = 1'b1;
        if (stat.last_step) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

`ifndef SYNTHESIS
  a_last_ends_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) && stat.last_step |=> (state_r == ST_IDLE))
    else $error("read burst did not end after its last step");

  a_load_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> busy)
    else $error("busy not raised after a read was loaded");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.push, cmd.load, cmd.step, cmd.emit_empty}))
    else $error("more than one datapath action in a cycle");
`endif

endmodule

>>> rtl/core/ierf_dp.sv
module ierf_dp #(
  parameter int unsigned RING_DEPTH = ierf_pkg::RING_DEPTH_DEF,
  parameter int unsigned MAX_READ   = ierf_pkg::MAX_READ_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ierf_pkg::ctrl_cmd_t                 cmd,
  output ierf_pkg::dp_stat_t                  stat,
  input  logic                                grab,
  input  logic [ierf_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [ierf_pkg::XY_W-1:0]    in_mouse_x,
  input  logic signed [ierf_pkg::XY_W-1:0]    in_mouse_y,
  input  logic [ierf_pkg::BYTE_W-1:0]         in_buttons,
  input  logic [ierf_pkg::BYTE_W-1:0]         in_key_code,
  input  logic [ierf_pkg::BYTE_W-1:0]         in_modifiers,
  input  logic                                in_key_pressed,
  input  logic [ierf_pkg::LIMIT_W-1:0]        in_read_limit,
  output logic                                out_valid,
  output logic                                out_empty_res,
  output logic                                out_ev_kind,
  output logic [ierf_pkg::BYTE_W-1:0]         out_ev_flags,
  output logic [ierf_pkg::BYTE_W-1:0]         out_ev_code,
  output logic                                out_ev_pressed,
  output logic signed [ierf_pkg::XY_W-1:0]    out_ev_x,
  output logic signed [ierf_pkg::XY_W-1:0]    out_ev_y,
  output logic                                out_last
);
  import ierf_pkg::*;

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = $clog2(MAX_READ + 1);
  localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(RING_DEPTH - 1);
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = LIMIT_W'(MAX_READ);

  ev_t              mem [RING_DEPTH];
  ev_t              mem_q_r;
  ev_t              push_ev;

  logic [PTR_W-1:0] rd_r, rd_nxt, rd_inc;
  logic [PTR_W-1:0] wr_r, wr_nxt, wr_inc;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LIMIT_W-1:0] limit;
  logic             push_ok;

  logic out_valid_r, out_valid_nxt;
  logic out_empty_r, out_empty_nxt;
  logic out_last_r,  out_last_nxt;

  assign rd_inc = (rd_r == PTR_LAST) ? '0 : rd_r + 1'b1;
  assign wr_inc = (wr_r == PTR_LAST) ? '0 : wr_r + 1'b1;

  // A full ring keeps one slot free; the new event is dropped then.
  assign push_ok = cmd.push && grab && (wr_inc != rd_r);

  always_comb begin
    push_ev = '0;
    if (in_cmd == CMD_PUSH_KEY) begin
      push_ev.kind    = KIND_KEY;
      push_ev.flags   = in_modifiers;
      push_ev.code    = in_key_code;
      push_ev.pressed = in_key_pressed;
    end else begin
      push_ev.kind  = KIND_MOUSE;
      push_ev.flags = {{(BYTE_W-BTN_W){1'b0}}, in_buttons[BTN_W-1:0]};
      push_ev.x     = in_mouse_x;
      push_ev.y     = in_mouse_y;
    end
  end

  // Read length clamps into one to MAX_READ.
  always_comb begin
    if (in_read_limit == '0) begin
      limit = LIMIT_W'(1);
    end else if (in_read_limit > LIMIT_MAX) begin
      limit = LIMIT_MAX;
    end else begin
      limit = in_read_limit;
    end
  end

  assign stat.ring_empty = (rd_r == wr_r);
  assign stat.last_step  = (cnt_r == CNT_W'(1)) || (rd_inc == wr_r);

  always_comb begin
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_empty_nxt = out_empty_r;
    out_last_nxt  = out_last_r;
    if (push_ok) begin
      wr_nxt = wr_inc;
    end
    if (cmd.load) begin
      cnt_nxt = limit[CNT_W-1:0];
    end
    if (cmd.step) begin
      rd_nxt        = rd_inc;
      cnt_nxt       = cnt_r - 1'b1;
      out_valid_nxt = 1'b1;
      out_empty_nxt = 1'b0;
      out_last_nxt  = stat.last_step;
    end
    if (cmd.emit_empty) begin
      out_valid_nxt = 1'b1;
      out_empty_nxt = 1'b1;
      out_last_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r        <= '0;
      wr_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_r        <= rd_nxt;
      wr_r        <= wr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    out_empty_r <= out_empty_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_r] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      mem_q_r <= mem[rd_r];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_empty_res  = out_empty_r;
  assign out_last       = out_last_r;
  assign out_ev_kind    = out_empty_r ? 1'b0 : mem_q_r.kind;
  assign out_ev_flags   = out_empty_r ? '0 : mem_q_r.flags;
  assign out_ev_code    = out_empty_r ? '0 : mem_q_r.code;
  assign out_ev_pressed = out_empty_r ? 1'b0 : mem_q_r.pressed;
  assign out_ev_x       = out_empty_r ? '0 : mem_q_r.x;
  assign out_ev_y       = out_empty_r ? '0 : mem_q_r.y;

`ifndef SYNTHESIS
  a_step_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (rd_r != wr_r))
    else $error("read step taken from an empty ring");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_last_r)
    else $error("empty result not marked last");

  a_push_keeps_gap: assert property (@(posedge clk) disable iff (!rst_n)
    push_ok |=> (wr_r != rd_r))
    else $error("push filled the reserved slot");
`endif

endmodule

>>> rtl/core/input_event_ring_fifo_core.sv
// Channel   Handshake                   Payload
// -------   -------------------------   -----------------------------------------------
// input     start / busy                in_cmd, in_mouse_x/y, in_buttons, in_key_code,
//                                       in_modifiers, in_key_pressed, in_read_limit
// result    out_valid (per result)      out_empty_res, out_ev_*, out_last
// config    psel/penable/pwrite/pready  paddr, pwdata, prdata (grab_enable at 0x0)
//
// busy stays low during a push, so pushes can arrive back to back.
// A read holds busy while its events are read, one ring memory read per cycle;
// results come out one per cycle, the first once the read state is entered and the result registers load.
// A read of an empty ring gives its single result in the next cycle, without busy.
// The rate of a read is set by the single registered read port of the ring memory.
// rst_n is synchronous and clears the pointers, the grab register and the state;
// the ring memory is not cleared. The receiver cannot stall the result channel.
module input_event_ring_fifo_core #(
  parameter int unsigned RING_DEPTH = ierf_pkg::RING_DEPTH_DEF,
  parameter int unsigned MAX_READ   = ierf_pkg::MAX_READ_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input transfers.
  input  logic                             start,
  output logic                             busy,
  input  logic [ierf_pkg::CMD_W-1:0]       in_cmd,
  input  logic signed [ierf_pkg::XY_W-1:0] in_mouse_x,
  input  logic signed [ierf_pkg::XY_W-1:0] in_mouse_y,
  input  logic [ierf_pkg::BYTE_W-1:0]      in_buttons,
  input  logic [ierf_pkg::BYTE_W-1:0]      in_key_code,
  input  logic [ierf_pkg::BYTE_W-1:0]      in_modifiers,
  input  logic                             in_key_pressed,
  input  logic [ierf_pkg::LIMIT_W-1:0]     in_read_limit,
  // Result transfers.
  output logic                             out_valid,
  output logic                             out_empty_res,
  output logic                             out_ev_kind,
  output logic [ierf_pkg::BYTE_W-1:0]      out_ev_flags,
  output logic [ierf_pkg::BYTE_W-1:0]      out_ev_code,
  output logic                             out_ev_pressed,
  output logic signed [ierf_pkg::XY_W-1:0] out_ev_x,
  output logic signed [ierf_pkg::XY_W-1:0] out_ev_y,
  output logic                             out_last,
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ierf_pkg::APB_AW-1:0]      paddr,
  input  logic [ierf_pkg::APB_DW-1:0]      pwdata,
  output logic [ierf_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);
  import ierf_pkg::*;

  ctrl_cmd_t ctl;
  dp_stat_t  stat;
  logic      grab;

  // The grab register gates pushes; reads work either way.
  ierf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .grab    (grab)
  );

  // The controller decodes each accepted command and sequences read bursts.
  ierf_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (stat),
    .cmd    (ctl),
    .busy   (busy)
  );

  // The datapath holds the ring memory, its two pointers, the burst counter
  // and the result registers.
  ierf_dp #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_READ   (MAX_READ)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (ctl),
    .stat           (stat),
    .grab           (grab),
    .in_cmd         (in_cmd),
    .in_mouse_x     (in_mouse_x),
    .in_mouse_y     (in_mouse_y),
    .in_buttons     (in_buttons),
    .in_key_code    (in_key_code),
    .in_modifiers   (in_modifiers),
    .in_key_pressed (in_key_pressed),
    .in_read_limit  (in_read_limit),
    .out_valid      (out_valid),
    .out_empty_res  (out_empty_res),
    .out_ev_kind    (out_ev_kind),
    .out_ev_flags   (out_ev_flags),
    .out_ev_code    (out_ev_code),
    .out_ev_pressed (out_ev_pressed),
    .out_ev_x       (out_ev_x),
    .out_ev_y       (out_ev_y),
    .out_last       (out_last)
  );

endmodule

>>> sim/tb_input_event_ring_fifo_core.sv
module tb_input_event_ring_fifo_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ierf_pkg::*;

  // Clocking, reset and run limits.
  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 5;
  // A push leaves no trace on the result side, so before a register write we
  // give the block time to finish whatever it may still be doing.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LIMIT  = 10;

  // The fourth command code has no meaning and must be dropped by the block.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Register i sits at byte address 4*i; bit 2 of paddr selects the register.
  localparam logic [APB_AW-1:0] ADDR_GRAB     = {REG_GRAB, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_UNMAPPED = {~REG_GRAB, 2'b00};

  // One command as it is presented on the input channel.
  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic signed [XY_W-1:0] mouse_x;
    logic signed [XY_W-1:0] mouse_y;
    logic [BYTE_W-1:0]      buttons;
    logic [BYTE_W-1:0]      key_code;
    logic [BYTE_W-1:0]      modifiers;
    logic                   key_pressed;
    logic [LIMIT_W-1:0]     read_limit;
  } input_cmd_t;

  // One event as it leaves the result channel.
  typedef struct packed {
    logic                   empty_res;
    logic                   kind;
    logic [BYTE_W-1:0]      flags;
    logic [BYTE_W-1:0]      code;
    logic                   pressed;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic                   last;
  } event_result_t;

  // A directed step is either a command or a register write.
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    input_cmd_t         item;
    logic               fixed;
    event_result_t      fixed_res;
    logic [APB_AW-1:0]  addr;
    logic [APB_DW-1:0]  data;
  } stim_row_t;

  // Block ports.
  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [CMD_W-1:0]       in_cmd;
  logic signed [XY_W-1:0] in_mouse_x;
  logic signed [XY_W-1:0] in_mouse_y;
  logic [BYTE_W-1:0]      in_buttons;
  logic [BYTE_W-1:0]      in_key_code;
  logic [BYTE_W-1:0]      in_modifiers;
  logic                   in_key_pressed;
  logic [LIMIT_W-1:0]     in_read_limit;
  logic                   out_valid;
  logic                   out_empty_res;
  logic                   out_ev_kind;
  logic [BYTE_W-1:0]      out_ev_flags;
  logic [BYTE_W-1:0]      out_ev_code;
  logic                   out_ev_pressed;
  logic signed [XY_W-1:0] out_ev_x;
  logic signed [XY_W-1:0] out_ev_y;
  logic                   out_last;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_AW-1:0]      paddr;
  logic [APB_DW-1:0]      pwdata;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  // Our own copy of the event ring. With 256 slots the 8-bit pointers wrap
  // by themselves, and the ring counts as full when the write pointer sits
  // one slot behind the read pointer.
  ev_t           ring_mem [RING_DEPTH_DEF];
  logic [7:0]    rd_ptr;
  logic [7:0]    wr_ptr;
  logic          grab_on;

  // Events the block still owes us, oldest first.
  event_result_t expected_results [$];

  int  mismatch_count;
  int  cycle_count;
  bit  idle_on;

  input_event_ring_fifo_core DUT (.*);

  always #CLK_HALF clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic input_cmd_t make_cmd(logic [CMD_W-1:0] cmd, int x, int y, int buttons,
                                          int code, int mods, bit pressed, int limit);
    input_cmd_t c;
    c.cmd         = cmd;
    c.mouse_x     = x[XY_W-1:0];
    c.mouse_y     = y[XY_W-1:0];
    c.buttons     = buttons[BYTE_W-1:0];
    c.key_code    = code[BYTE_W-1:0];
    c.modifiers   = mods[BYTE_W-1:0];
    c.key_pressed = pressed;
    c.read_limit  = limit[LIMIT_W-1:0];
    return c;
  endfunction

  function automatic event_result_t make_result(logic empty, logic kind,
                                                logic [BYTE_W-1:0] flags,
                                                logic [BYTE_W-1:0] code, logic pressed,
                                                logic signed [XY_W-1:0] x,
                                                logic signed [XY_W-1:0] y, logic last);
    event_result_t r;
    r.empty_res = empty;
    r.kind      = kind;
    r.flags     = flags;
    r.code      = code;
    r.pressed   = pressed;
    r.x         = x;
    r.y         = y;
    r.last      = last;
    return r;
  endfunction

  function automatic stim_row_t row_item(input_cmd_t c);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item = c;
    return r;
  endfunction

  function automatic stim_row_t row_fixed(input_cmd_t c, event_result_t res);
    stim_row_t r;
    r = row_item(c);
    r.fixed     = 1'b1;
    r.fixed_res = res;
    return r;
  endfunction

  function automatic stim_row_t row_cfg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.addr = addr;
    r.data = data;
    return r;
  endfunction

  function automatic string show_result(event_result_t r);
    return $sformatf("empty=%0d kind=%0d flags=%02h code=%02h pressed=%0d x=%0d y=%0d last=%0d",
                     r.empty_res, r.kind, r.flags, r.code, r.pressed, r.x, r.y, r.last);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  // Queue one event unless grab is off or the ring is already full.
  function automatic void queue_event(ev_t ev);
    logic [7:0] nxt;
    nxt = wr_ptr + 8'd1;
    if (grab_on && nxt != rd_ptr) begin
      ring_mem[wr_ptr] = ev;
      wr_ptr = nxt;
    end
  endfunction

  // Apply one accepted command to our copy of the ring and append whatever
  // events the block is expected to send back for it.
  function automatic void predict_command(input_cmd_t c);
    ev_t         ev;
    int unsigned limit;
    ev = '0;
    case (c.cmd)
      CMD_PUSH_MOUSE: begin
        ev.kind  = KIND_MOUSE;
        ev.flags = {{(BYTE_W-BTN_W){1'b0}}, c.buttons[BTN_W-1:0]};
        ev.x     = c.mouse_x;
        ev.y     = c.mouse_y;
        queue_event(ev);
      end
      CMD_PUSH_KEY: begin
        ev.kind    = KIND_KEY;
        ev.flags   = c.modifiers;
        ev.code    = c.key_code;
        ev.pressed = c.key_pressed;
        queue_event(ev);
      end
      CMD_READ: begin
        // A limit of zero still returns one event; anything above the burst
        // size is clipped to it.
        limit = 32'(c.read_limit);
        if (limit == 0) limit = 1;
        if (limit > MAX_READ_DEF) limit = MAX_READ_DEF;
        if (rd_ptr == wr_ptr) begin
          expected_results.push_back(make_result(1'b1, KIND_MOUSE, '0, '0, 1'b0, '0, '0, 1'b1));
        end else begin
          for (int unsigned n = 0; n < limit && rd_ptr != wr_ptr; n++) begin
            ev = ring_mem[rd_ptr];
            rd_ptr = rd_ptr + 8'd1;
            expected_results.push_back(make_result(1'b0, ev.kind, ev.flags, ev.code,
                                                   ev.pressed, ev.x, ev.y,
                                                   (n + 1 == limit) || (rd_ptr == wr_ptr)));
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Present one command at the falling edge and hold it until the block takes
  // it. busy is read at the rising edge, before the block updates it, so the
  // transfer happens exactly at the edge where start is high and busy is low.
  // A fixed row replaces whatever the predictor would expect with the value
  // typed into the table; the predictor still runs to keep the ring in step.
  task automatic run_item(input input_cmd_t c, input bit fixed, input event_result_t fixed_res);
    int depth_before;
    @(negedge clk);
    start          <= 1'b1;
    in_cmd         <= c.cmd;
    in_mouse_x     <= c.mouse_x;
    in_mouse_y     <= c.mouse_y;
    in_buttons     <= c.buttons;
    in_key_code    <= c.key_code;
    in_modifiers   <= c.modifiers;
    in_key_pressed <= c.key_pressed;
    in_read_limit  <= c.read_limit;
    do @(posedge clk); while (busy);
    depth_before = expected_results.size();
    predict_command(c);
    if (fixed) begin
      while (expected_results.size() > depth_before) void'(expected_results.pop_back());
      expected_results.push_back(fixed_res);
    end
  endtask

  // The sender drops start for a random burst of cycles now and then.
  task automatic idle_gap();
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Register write with the block at rest, followed by a read-back of the
  // grab register. Only the word address selects a register; writes to any
  // other word are dropped.
  task automatic write_register(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[2] == REG_GRAB) grab_on = data[0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_GRAB;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DW'(grab_on)) begin
      report_mismatch($sformatf("grab register read: expected %08h, got %08h",
                                APB_DW'(grab_on), prdata));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly pushes with some reads, so the ring fills and drains in turns.
  // Every field is random on every command, whether the command uses it or not.
  function automatic input_cmd_t random_command();
    input_cmd_t c;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      c.cmd = CMD_PUSH_MOUSE;
    else if (pick < 75) c.cmd = CMD_PUSH_KEY;
    else if (pick < 95) c.cmd = CMD_READ;
    else                c.cmd = CMD_UNUSED;
    c.mouse_x     = XY_W'($urandom);
    c.mouse_y     = XY_W'($urandom);
    c.buttons     = BYTE_W'($urandom);
    c.key_code    = BYTE_W'($urandom);
    c.modifiers   = BYTE_W'($urandom);
    c.key_pressed = 1'($urandom_range(0, 1));
    c.read_limit  = LIMIT_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                          : $urandom_range(1, 8));
    return c;
  endfunction

  task automatic run_random(input int count);
    repeat (count) begin
      idle_gap();
      run_item(random_command(), 1'b0, '0);
    end
  endtask

  // Result checker: every strobe must match the oldest outstanding event.
  always @(posedge clk) begin : result_check
    event_result_t seen;
    event_result_t want;
    if (rst_n && out_valid) begin
      seen.empty_res = out_empty_res;
      seen.kind      = out_ev_kind;
      seen.flags     = out_ev_flags;
      seen.code      = out_ev_code;
      seen.pressed   = out_ev_pressed;
      seen.x         = out_ev_x;
      seen.y         = out_ev_y;
      seen.last      = out_last;
      if (expected_results.size() == 0) begin
        report_mismatch({"result with nothing outstanding: ", show_result(seen)});
      end else begin
        want = expected_results.pop_front();
        if (seen !== want) begin
          report_mismatch({"result mismatch\n  expected ", show_result(want),
                           "\n  actual   ", show_result(seen)});
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t     directed_rows [$];
    event_result_t empty_read;
    input_cmd_t    c;

    clk            = 1'b0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_cmd         = CMD_PUSH_MOUSE;
    in_mouse_x     = '0;
    in_mouse_y     = '0;
    in_buttons     = '0;
    in_key_code    = '0;
    in_modifiers   = '0;
    in_key_pressed = 1'b0;
    in_read_limit  = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    rd_ptr         = '0;
    wr_ptr         = '0;
    grab_on        = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    idle_on        = 1'b1;

    empty_read = make_result(1'b1, KIND_MOUSE, '0, '0, 1'b0, '0, '0, 1'b1);

    // Directed steps. Grab is off after reset, so the first pushes vanish and
    // reads find an empty ring. A write to the unused word must leave grab off.
    // Then single events at the field extremes are pushed and read back, the
    // button mask and the read limit clipping are exercised, and a read with
    // grab switched off shows that reads ignore the grab setting.
    directed_rows.push_back(row_fixed(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0), empty_read));
    directed_rows.push_back(row_item(make_cmd(CMD_PUSH_MOUSE, 100, -100, 'h07, 0, 0, 0, 0)));
    directed_rows.push_back(row_item(make_cmd(CMD_PUSH_KEY, 0, 0, 0, 'h41, 'h01, 1, 0)));
    directed_rows.push_back(row_fixed(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 64), empty_read));
    directed_rows.push_back(row_item(make_cmd(CMD_UNUSED, -1, -1, 'hFF, 'hFF, 'hFF, 1, 127)));
    directed_rows.push_back(row_cfg(ADDR_UNMAPPED, 32'hFFFF_FFFF));
    directed_rows.push_back(row_item(make_cmd(CMD_PUSH_MOUSE, 5, 5, 'h01, 0, 0, 0, 0)));
    directed_rows.push_back(row_fixed(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 1), empty_read));
    directed_rows.push_back(row_cfg(ADDR_GRAB, 32'h0000_0001));
    directed_rows.push_back(row_item(make_cmd(CMD_PUSH_MOUSE, -32768, 32767, 'hFF, 'hFF, 'hFF,
                                              1, 127)));
    directed_rows.push_back(row_fixed(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 1),
                                      make_result(1'b0, KIND_MOUSE, 8'h07, 8'h00, 1'b0,
                                                  -16'sd32768, 16'sd32767, 1'b1)));
    directed_rows.push_back(row_item(make_cmd(CMD_PUSH_KEY, -1, -1, 'hFF, 'hFF, 'hFF, 1, 127)));
    directed_rows.push_back(row_fixed(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 127),
                                      make_result(1'b0, KIND_KEY, 8'hFF, 8'hFF, 1'b1,
                                                  16'sd0, 16'sd0, 1'b1)));
    directed_rows.push_back(row_item(make_cmd(CMD_PUSH_MOUSE, 32767, -32768, 'hF8, 0, 0, 0, 0)));
    directed_rows.push_back(row_item(make_cmd(CMD_PUSH_KEY, 0, 0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(row_item(make_cmd(CMD_PUSH_MOUSE, -1, 0, 'h05, 0, 0, 0, 0)));
    directed_rows.push_back(row_item(make_cmd(CMD_UNUSED, 1, 1, 1, 1, 1, 1, 2)));
    directed_rows.push_back(row_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 2)));
    directed_rows.push_back(row_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 65)));
    directed_rows.push_back(row_fixed(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 1), empty_read));
    directed_rows.push_back(row_item(make_cmd(CMD_PUSH_KEY, 0, 0, 0, 'h41, 'h80, 1, 0)));
    directed_rows.push_back(row_cfg(ADDR_GRAB, 32'hFFFF_FFFE));
    directed_rows.push_back(row_item(make_cmd(CMD_PUSH_MOUSE, 7, 7, 'h07, 0, 0, 0, 0)));
    directed_rows.push_back(row_item(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 64)));
    directed_rows.push_back(row_fixed(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 1), empty_read));

    // Synchronous reset, released on a falling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_register(directed_rows[i].addr, directed_rows[i].data);
      end else begin
        idle_gap();
        run_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].fixed_res);
      end
    end

    // Random traffic with grab on. Halfway through, the sender holds off
    // until the block has delivered every outstanding event.
    write_register(ADDR_GRAB, 32'hFFFF_FFFF);
    run_random(6);
    wait_for_results();
    run_random(6);

    // Grab off: pushes are ignored while reads keep draining the ring.
    write_register(ADDR_GRAB, 32'h0000_0000);
    run_random(5);

    // Grab on and a full ring's worth of pushes, so the last ones find the
    // ring full and are dropped. Long reads then empty it again.
    write_register(ADDR_GRAB, 32'h0000_0001);
    repeat (RING_DEPTH_DEF) begin
      idle_gap();
      c = random_command();
      c.cmd = $urandom_range(0, 1) ? CMD_PUSH_KEY : CMD_PUSH_MOUSE;
      run_item(c, 1'b0, '0);
    end
    while (rd_ptr != wr_ptr) begin
      idle_gap();
      c = random_command();
      c.cmd        = CMD_READ;
      c.read_limit = LIMIT_W'($urandom_range(32, 64));
      run_item(c, 1'b0, '0);
    end

    // Closing stretch: commands back to back with no idle cycles.
    idle_on = 1'b0;
    run_random(6);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
